### hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the stream find/replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int REPL_MAX        = 8;
	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int REPL_IDX_W      = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE       = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              in_last;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic              out_last;
	} out_t;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DROP,
		OP_REPL,
		OP_CLEAR,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic held_zero;
		logic is_prefix;
		logic at_length;
		logic rlen_zero;
		logic repl_last;
		logic last;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c, input logic ic);
		if (ic && (c >= 8'h41) && (c <= 8'h5A)) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// Sequencer: accepts one request, then steps the datapath through
// release, replace, flush and finish.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sfr_pkg::dp_status_t status,
	output sfr_pkg::op_t        op
);
	import sfr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_REPL   = 5'b00100,
		S_FLUSH  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.held_zero) begin
					state_d = S_FINISH;
				end else if (!status.is_prefix) begin
					// front byte can no longer start a match
					if (status.out_free) begin
						op = OP_DROP;
					end
				end else if (status.at_length) begin
					if (status.rlen_zero) begin
						op = OP_CLEAR;
					end else begin
						state_d = S_REPL;
					end
				end else if (status.last) begin
					state_d = S_FLUSH;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_REPL: begin
				if (status.out_free) begin
					op = OP_REPL;
					if (status.repl_last) begin
						state_d = S_SCAN;
					end
				end
			end
			S_FLUSH: begin
				if (status.held_zero) begin
					state_d = S_FINISH;
				end else if (status.out_free) begin
					op = OP_DROP;
				end
			end
			S_FINISH: begin
				if (status.out_free) begin
					op      = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// finish always drains the pending result before the next request
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !status.pend_valid)
		else $error("pending result left over in idle");

	a_repl_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REPL |-> !status.rlen_zero)
		else $error("replace sequence with empty replacement");

	a_drop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_DROP |-> !status.held_zero)
		else $error("drop from empty hold buffer");
`endif

endmodule

`default_nettype wire

### hw/rtl/sfr_dpath.sv
// ----------------------------------------------------------------------------
// sfr_dpath
// Config registers, hold buffer with prefix compare, replacement index,
// one-deep pending result and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_dpath #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sfr_pkg::in_t                        in_data,
	input  logic                                cfg_valid,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  sfr_pkg::op_t                        op,
	output sfr_pkg::dp_status_t                 status,
	input  logic                                out_stall,
	output logic                                out_valid,
	output sfr_pkg::out_t                       out_data
);
	import sfr_pkg::*;

	localparam int CNT_W = $clog2(PATTERN_MAX + 1);

	// configuration
	logic [CFG_DATA_W-1:0] pat_q;
	logic [LEN_W-1:0]      plen_q;
	logic [CFG_DATA_W-1:0] repl_q;
	logic [LEN_W-1:0]      rlen_q;
	logic                  ic_q;

	// hold buffer and control
	logic [BYTE_W-1:0]     held_q [PATTERN_MAX];
	logic [CNT_W-1:0]      cnt_q;
	logic [REPL_IDX_W-1:0] ridx_q;
	logic                  last_q;
	logic [BYTE_W-1:0]     pend_q;
	logic                  pend_v_q;
	logic                  out_v_q;
	out_t                  out_q;

	logic [LEN_W-1:0]      plen;
	logic [LEN_W-1:0]      rlen;
	logic [LEN_W-1:0]      cnt_ext;
	logic                  match_all;
	logic                  repl_last;
	logic                  out_free;
	logic                  emits;
	logic                  push;
	logic [BYTE_W-1:0]     new_byte;
	out_t                  out_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= LEN_W'(1);
			repl_q <= '0;
			rlen_q <= '0;
			ic_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PATTERN_BYTES:     pat_q  <= cfg_data;
				CFG_PATTERN_LENGTH:    plen_q <= cfg_data[LEN_W-1:0];
				CFG_REPLACEMENT_BYTES: repl_q <= cfg_data;
				CFG_REPLACEMENT_LEN:   rlen_q <= cfg_data[LEN_W-1:0];
				CFG_IGNORE_CASE:       ic_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective lengths, saturated
	always_comb begin
		if (plen_q == '0) begin
			plen = LEN_W'(1);
		end else if (plen_q > LEN_W'(PATTERN_MAX)) begin
			plen = LEN_W'(PATTERN_MAX);
		end else begin
			plen = plen_q;
		end
		if (rlen_q > LEN_W'(REPL_MAX)) begin
			rlen = LEN_W'(REPL_MAX);
		end else begin
			rlen = rlen_q;
		end
	end

	assign cnt_ext = LEN_W'(cnt_q);

	always_comb begin
		match_all = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if ((CNT_W'(i) < cnt_q) &&
			    (fold(held_q[i], ic_q) != fold(pat_q[BYTE_W*i +: BYTE_W], ic_q))) begin
				match_all = 1'b0;
			end
		end
	end

	assign repl_last = (LEN_W'(ridx_q) == (rlen - LEN_W'(1)));
	assign out_free  = !out_v_q || !out_stall;
	assign emits     = (op == OP_DROP) || (op == OP_REPL);
	assign push      = (emits && pend_v_q) || ((op == OP_FINISH) && (pend_v_q || last_q));
	assign new_byte  = (op == OP_REPL) ? repl_q[BYTE_W*ridx_q +: BYTE_W] : held_q[0];

	always_comb begin
		if (op != OP_FINISH) begin
			out_next = '{out_byte: pend_q, has_byte: 1'b1, out_last: 1'b0};
		end else if (pend_v_q) begin
			out_next = '{out_byte: pend_q, has_byte: 1'b1, out_last: last_q};
		end else begin
			// bare end mark
			out_next = '{out_byte: '0, has_byte: 1'b0, out_last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ridx_q   <= '0;
			last_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			case (op)
				OP_LOAD: begin
					cnt_q  <= cnt_q + CNT_W'(1);
					last_q <= in_data.in_last;
				end
				OP_DROP: begin
					cnt_q    <= cnt_q - CNT_W'(1);
					pend_v_q <= 1'b1;
				end
				OP_REPL: begin
					pend_v_q <= 1'b1;
					if (repl_last) begin
						cnt_q  <= '0;
						ridx_q <= '0;
					end else begin
						ridx_q <= ridx_q + REPL_IDX_W'(1);
					end
				end
				OP_CLEAR: begin
					cnt_q <= '0;
				end
				OP_FINISH: begin
					pend_v_q <= 1'b0;
				end
				default: ;
			endcase
			if (push) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				for (int i = 0; i < PATTERN_MAX; i++) begin
					if (cnt_q == CNT_W'(i)) begin
						held_q[i] <= in_data.in_byte;
					end
				end
			end
			OP_DROP: begin
				for (int i = 0; i < PATTERN_MAX - 1; i++) begin
					held_q[i] <= held_q[i+1];
				end
			end
			default: ;
		endcase
		if (emits) begin
			pend_q <= new_byte;
		end
		if (push) begin
			out_q <= out_next;
		end
	end

	assign status = '{
		held_zero:  (cnt_q == '0),
		is_prefix:  (cnt_ext <= plen) && match_all,
		at_length:  (cnt_ext == plen),
		rlen_zero:  (rlen == '0),
		repl_last:  repl_last,
		last:       last_q,
		pend_valid: pend_v_q,
		out_free:   out_free
	};

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PATTERN_MAX))
		else $error("hold count beyond buffer depth");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_LOAD |-> cnt_q < CNT_W'(PATTERN_MAX))
		else $error("request loaded into full hold buffer");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_FINISH |=> !pend_v_q)
		else $error("pending result survived finish");

	// a push must never overwrite a result still waiting downstream
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

### hw/rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace-all over a byte stream with optional
// case-insensitive matching and end-of-string flush.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | in_data  : in_byte, in_last
//  out     | out_valid / out_stall | out_data : out_byte, has_byte, out_last
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (ready always high)
//
//  One request at a time; the sequencer emits one result per cycle, while the
//  output register is free, through a one-deep pending register.
//  A replacement is emitted in the replace state; an end of string with held
//  bytes is released in the flush state.
//  Reset clears config to defaults, the hold count and all valid flags.
//  A stalled output register holds its result; the sequencer waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  sfr_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output sfr_pkg::out_t                  out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfr_pkg::*;

	op_t        op;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	sfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.op       (op)
	);

	sfr_dpath #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op        (op),
		.status    (status),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
